[rtl/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain concurrent assertion on the rising clock, off while reset is low.
`define TLC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Antecedent in a cycle, consequent in the next.
`define TLC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    `TLC_ASSERT(label, clk, rst_n, (ante) |=> (cons), msg)

`endif

[rtl/tlc_pkg.sv]
package tlc_pkg;

    localparam int unsigned POW_TABLE_DEPTH_DEF = 1024;

    // restoring divider: 18 quotient bits, top one always zero once the
    // ratio is known to stay below 2.0
    localparam int DIV_STEPS           = 18;
    localparam int DIV_STEPS_PER_STAGE = 3;
    localparam int DIV_STAGES          = DIV_STEPS / DIV_STEPS_PER_STAGE;
    // divider stages plus select, product, scale and output stages
    localparam int PIPE_STAGES         = DIV_STAGES + 4;

    localparam logic [16:0] BOUND_050 = 17'd32768;
    localparam logic [16:0] BOUND_061 = 17'd39976;
    localparam logic [16:0] BOUND_080 = 17'd52428;
    localparam logic [16:0] BOUND_130 = 17'd85196;

    // coefficients in Q24
    localparam logic [19:0] K_S1_A = 20'd510027;
    localparam logic [19:0] K_S1_B = 20'd1040187;
    localparam logic [19:0] K_S2_A = 20'd375810;
    localparam logic [19:0] K_S2_B = 20'd520094;
    localparam logic [19:0] K_S3_A = 20'd214748;
    localparam logic [19:0] K_S3_B = 20'd256691;
    localparam logic [19:0] K_S4_A = 20'd24495;
    localparam logic [19:0] K_S4_B = 20'd18790;

    localparam logic [18:0] LUX_MAX = 19'd524287;

    typedef enum logic [2:0] {
        SEG_CH0_ZERO = 3'd0,
        SEG_LOW      = 3'd1,
        SEG_MID      = 3'd2,
        SEG_UPPER    = 3'd3,
        SEG_TOP      = 3'd4,
        SEG_OVER     = 3'd5
    } t_seg;

    typedef struct packed {
        logic [15:0] rem;
        logic [17:0] q;
        logic [15:0] ch0;
        logic [15:0] ch1;
        logic        zero;
        logic        ovf;
    } t_div_word;

    // one restoring step: returns {quotient bit, new remainder}
    function automatic logic [16:0] div_step(input logic [15:0] rem, input logic nbit,
                                             input logic [15:0] d);
        logic [16:0] sh;
        logic [16:0] diff;
        sh   = {rem, nbit};
        diff = sh - {1'b0, d};
        if (sh >= {1'b0, d}) begin
            return {1'b1, diff[15:0]};
        end
        return {1'b0, sh[15:0]};
    endfunction

    // dividend is ch1 << 16: only the two leading steps bring in ch1 bits
    function automatic logic div_bit(input logic [15:0] c1, input int k);
        if (k == DIV_STEPS - 1) begin
            return c1[1];
        end
        if (k == DIV_STEPS - 2) begin
            return c1[0];
        end
        return 1'b0;
    endfunction

    // floor(2^16 * x^1.4) with x the midpoint of bin idx, found exactly:
    // largest y with y^5 * (4*depth)^7 <= (2*idx+1)^7 * 2^80
    function automatic logic [15:0] pow_entry(input int unsigned depth,
                                              input int unsigned idx);
        logic [191:0] rhs;
        logic [191:0] lhs;
        logic [191:0] odd;
        logic [191:0] den;
        logic [15:0]  y;
        logic [15:0]  cand;
        odd = 192'(2 * idx + 1);
        den = 192'(4 * depth);
        rhs = 192'(1);
        for (int k = 0; k < 7; k++) begin
            rhs = rhs * odd;
        end
        rhs = rhs << 80;
        y = '0;
        for (int b = 15; b >= 0; b--) begin
            cand = y | (16'(1) << b);
            lhs  = 192'(cand);
            for (int k = 0; k < 4; k++) begin
                lhs = lhs * 192'(cand);
            end
            for (int k = 0; k < 7; k++) begin
                lhs = lhs * den;
            end
            if (lhs <= rhs) begin
                y = cand;
            end
        end
        return y;
    endfunction

endpackage

[rtl/tlc_if.sv]
interface tlc_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] ch0;
    logic [15:0] ch1;

    modport source (output valid, output ch0, output ch1, input ready);
    modport sink   (input valid, input ch0, input ch1, output ready);
endinterface

interface tlc_out_if;
    logic        valid;
    logic        ready;
    logic [18:0] lux_q8;
    logic [2:0]  segment;

    modport source (output valid, output lux_q8, output segment, input ready);
    modport sink   (input valid, input lux_q8, input segment, output ready);
endinterface

[rtl/two_channel_lux_calculator_top.sv]
// Two-channel lux calculator. Each item carries a broadband count ch0 and
// an infrared count ch1; each gives one result item with lux in unsigned
// Q11.8 and the formula segment used (0 when ch0 is zero, 5 when ch1/ch0
// is above 1.3). One item is taken per cycle while the output side is
// ready; the result passes through six stages of the restoring divider
// that forms the Q1.16 ratio, three quotient bits each, then segment
// select, the registered read of the ratio^1.4 ROM alongside the
// coefficient products, the second product of the lowest segment, and the
// output register. A stalled output holds the pipeline; empty stages still
// fill, so input is taken while any stage is free.
module two_channel_lux_calculator_top #(
    parameter int unsigned POW_TABLE_DEPTH = tlc_pkg::POW_TABLE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tlc_in_if.sink      i_in,
    tlc_out_if.source   o_out
);

    localparam int IDX_W = $clog2(POW_TABLE_DEPTH);
    localparam int DW    = $clog2(POW_TABLE_DEPTH + 1);
    localparam int PW    = 16 + DW;

    typedef logic [15:0] t_pow_rom [POW_TABLE_DEPTH];

    function automatic t_pow_rom build_rom();
        t_pow_rom rom;
        for (int i = 0; i < int'(POW_TABLE_DEPTH); i++) begin
            rom[i] = tlc_pkg::pow_entry(POW_TABLE_DEPTH, i);
        end
        return rom;
    endfunction

    localparam t_pow_rom POW_ROM = build_rom();

    typedef struct packed {
        tlc_pkg::t_seg    seg;
        logic [IDX_W-1:0] idx;
        logic [19:0]      ka;
        logic [19:0]      kb;
        logic [15:0]      ch0;
        logic [15:0]      xb;
    } t_sel;

    typedef struct packed {
        tlc_pkg::t_seg seg;
        logic [35:0]   pos;
        logic [35:0]   neg;
    } t_prod;

    typedef struct packed {
        tlc_pkg::t_seg seg;
        logic [18:0]   lux;
    } t_res;

    // divider
    logic               w_div_vld;
    logic               w_div_rdy;
    tlc_pkg::t_div_word w_div;

    // select, product, scale, output stages
    logic        r_a_vld, r_b_vld, r_c_vld, r_d_vld;
    logic        w_rdy_a, w_rdy_b, w_rdy_c, w_rdy_d;
    t_sel        r_a, n_a;
    t_prod       r_b, n_b;
    logic [15:0] r_b_pow;
    t_prod       r_c, n_c;
    t_res        r_d, n_d;

    logic [16:0]   w_ratio;
    logic [PW-1:0] w_idx_prod;
    logic [DW:0]   w_idx_hi;
    logic [51:0]   w_scaled;
    logic [35:0]   w_diff;

    tlc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_ch0   (i_in.ch0),
        .i_ch1   (i_in.ch1),
        .o_valid (w_div_vld),
        .i_ready (w_div_rdy),
        .o_res   (w_div)
    );

    assign w_rdy_d   = !r_d_vld || o_out.ready;
    assign w_rdy_c   = !r_c_vld || w_rdy_d;
    assign w_rdy_b   = !r_b_vld || w_rdy_c;
    assign w_rdy_a   = !r_a_vld || w_rdy_b;
    assign w_div_rdy = w_rdy_a;

    // segment select and ROM index
    assign w_ratio    = w_div.q[16:0];
    assign w_idx_prod = PW'(w_div.q[15:0]) * PW'(POW_TABLE_DEPTH);
    assign w_idx_hi   = w_idx_prod[PW-1:15];

    always_comb begin
        n_a.ch0 = w_div.ch0;
        priority if (w_div.zero) begin
            n_a.seg = tlc_pkg::SEG_CH0_ZERO;
        end else if (w_div.ovf) begin
            n_a.seg = tlc_pkg::SEG_OVER;
        end else if (w_ratio <= tlc_pkg::BOUND_050) begin
            n_a.seg = tlc_pkg::SEG_LOW;
        end else if (w_ratio <= tlc_pkg::BOUND_061) begin
            n_a.seg = tlc_pkg::SEG_MID;
        end else if (w_ratio <= tlc_pkg::BOUND_080) begin
            n_a.seg = tlc_pkg::SEG_UPPER;
        end else if (w_ratio <= tlc_pkg::BOUND_130) begin
            n_a.seg = tlc_pkg::SEG_TOP;
        end else begin
            n_a.seg = tlc_pkg::SEG_OVER;
        end

        // a ratio of exactly 0.5 lands one past the last bin
        if (w_idx_hi > (DW+1)'(POW_TABLE_DEPTH - 1)) begin
            n_a.idx = IDX_W'(POW_TABLE_DEPTH - 1);
        end else begin
            n_a.idx = w_idx_hi[IDX_W-1:0];
        end

        // zero coefficients make the outside cases come out as zero lux
        unique case (n_a.seg)
            tlc_pkg::SEG_LOW: begin
                n_a.ka = tlc_pkg::K_S1_A;
                n_a.kb = tlc_pkg::K_S1_B;
                n_a.xb = w_div.ch0;
            end
            tlc_pkg::SEG_MID: begin
                n_a.ka = tlc_pkg::K_S2_A;
                n_a.kb = tlc_pkg::K_S2_B;
                n_a.xb = w_div.ch1;
            end
            tlc_pkg::SEG_UPPER: begin
                n_a.ka = tlc_pkg::K_S3_A;
                n_a.kb = tlc_pkg::K_S3_B;
                n_a.xb = w_div.ch1;
            end
            tlc_pkg::SEG_TOP: begin
                n_a.ka = tlc_pkg::K_S4_A;
                n_a.kb = tlc_pkg::K_S4_B;
                n_a.xb = w_div.ch1;
            end
            default: begin
                n_a.ka = '0;
                n_a.kb = '0;
                n_a.xb = '0;
            end
        endcase
    end

    // coefficient products
    always_comb begin
        n_b.seg = r_a.seg;
        n_b.pos = 36'(r_a.ka) * 36'(r_a.ch0);
        n_b.neg = 36'(r_a.kb) * 36'(r_a.xb);
    end

    // lowest segment scales the negative term by ratio^1.4
    assign w_scaled = 52'(r_b.neg) * 52'(r_b_pow);

    always_comb begin
        n_c.seg = r_b.seg;
        n_c.pos = r_b.pos;
        if (r_b.seg == tlc_pkg::SEG_LOW) begin
            n_c.neg = w_scaled[51:16];
        end else begin
            n_c.neg = r_b.neg;
        end
    end

    assign w_diff = (r_c.pos > r_c.neg) ? (r_c.pos - r_c.neg) : 36'd0;

    always_comb begin
        n_d.seg = r_c.seg;
        if (w_diff[35]) begin
            n_d.lux = tlc_pkg::LUX_MAX;
        end else begin
            n_d.lux = w_diff[34:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else begin
            if (w_rdy_a) begin
                r_a_vld <= w_div_vld;
            end
            if (w_rdy_b) begin
                r_b_vld <= r_a_vld;
            end
            if (w_rdy_c) begin
                r_c_vld <= r_b_vld;
            end
            if (w_rdy_d) begin
                r_d_vld <= r_c_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy_a) begin
            r_a <= n_a;
        end
        if (w_rdy_b) begin
            r_b     <= n_b;
            r_b_pow <= POW_ROM[r_a.idx];
        end
        if (w_rdy_c) begin
            r_c <= n_c;
        end
        if (w_rdy_d) begin
            r_d <= n_d;
        end
    end

    assign o_out.valid   = r_d_vld;
    assign o_out.lux_q8  = r_d.lux;
    assign o_out.segment = r_d.seg;

endmodule

[rtl/tlc_div.sv]
module tlc_div (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [15:0]          i_ch0,
    input  logic [15:0]          i_ch1,
    output logic                 o_valid,
    input  logic                 i_ready,
    output tlc_pkg::t_div_word   o_res
);

    localparam int NS  = tlc_pkg::DIV_STAGES;
    localparam int SPS = tlc_pkg::DIV_STEPS_PER_STAGE;

    tlc_pkg::t_div_word r_stg [NS];
    tlc_pkg::t_div_word n_stg [NS];
    tlc_pkg::t_div_word w_in  [NS];
    logic               r_vld [NS];
    logic               w_vin [NS];
    logic               w_rdy [NS+1];

    assign w_rdy[NS] = i_ready;

    for (genvar s = 0; s < NS; s++) begin : g_stage
        if (s == 0) begin : g_first
            always_comb begin
                w_in[s].ch0  = i_ch0;
                w_in[s].ch1  = i_ch1;
                w_in[s].q    = '0;
                // start from the dividend bits above the quotient window
                w_in[s].rem  = {2'b00, i_ch1[15:2]};
                w_in[s].zero = (i_ch0 == 16'd0);
                // ratio of 2.0 or more lies beyond the last segment
                w_in[s].ovf  = ({1'b0, i_ch1} >= {i_ch0, 1'b0});
            end
            assign w_vin[s] = i_valid;
        end else begin : g_next
            assign w_in[s]  = r_stg[s-1];
            assign w_vin[s] = r_vld[s-1];
        end

        assign w_rdy[s] = !r_vld[s] || w_rdy[s+1];

        always_comb begin
            tlc_pkg::t_div_word cur;
            logic [16:0]        st;
            cur = w_in[s];
            for (int j = 0; j < SPS; j++) begin
                st = tlc_pkg::div_step(cur.rem,
                                       tlc_pkg::div_bit(cur.ch1,
                                           tlc_pkg::DIV_STEPS - 1 - s * SPS - j),
                                       cur.ch0);
                cur.q   = {cur.q[16:0], st[16]};
                cur.rem = st[15:0];
            end
            n_stg[s] = cur;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (w_rdy[s]) begin
                r_vld[s] <= w_vin[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[s]) begin
                r_stg[s] <= n_stg[s];
            end
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_vld[NS-1];
    assign o_res   = r_stg[NS-1];

endmodule

[rtl/tlc_checker.sv]
`include "assert_macros.svh"

module tlc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [18:0] i_lux_q8,
    input logic [2:0]  i_segment
);

    localparam int CW = $clog2(tlc_pkg::PIPE_STAGES + 2);

    logic          w_in_acc;
    logic          w_out_acc;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;

    // items inside the block
    always_comb begin
        n_count = r_count;
        if (w_in_acc && !w_out_acc) begin
            n_count = r_count + CW'(1);
        end else if (!w_in_acc && w_out_acc) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    `TLC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_lux_q8) && $stable(i_segment), "result changed while stalled")
    `TLC_ASSERT(a_ready_when_drained, i_clk, i_rst_n, !i_out_valid |-> i_in_ready, "input stalled with output register empty")
    `TLC_ASSERT(a_no_phantom, i_clk, i_rst_n, i_out_valid |-> (r_count != '0), "result without an item inside")
    `TLC_ASSERT(a_zero_outside, i_clk, i_rst_n, i_out_valid && (i_segment == tlc_pkg::SEG_CH0_ZERO || i_segment == tlc_pkg::SEG_OVER) |-> (i_lux_q8 == '0), "nonzero lux outside the formula segments")

endmodule

bind two_channel_lux_calculator_top tlc_checker u_tlc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_lux_q8    (o_out.lux_q8),
    .i_segment   (o_out.segment)
);
